FILE: hw/rtl/etr_pkg.sv
package etr_pkg;

  // Field widths fixed by the interface.
  localparam int TEXEL_W   = 32;
  localparam int FX_W      = 16;
  localparam int CFG_W     = 16;
  localparam int COLOR_W   = 24;
  localparam int HEIGHT_W  = 16;

  // Internal arithmetic widths.
  localparam int H_W       = 24;               // Terrarium height, signed Q.8 metres
  localparam int DIFF_W    = H_W + 1;          // difference of two heights
  localparam int PROD_W    = DIFF_W + FX_W + 1;// difference times an unsigned weight
  localparam int NUM_W     = H_W + 1;          // height minus floor, signed
  localparam int DEN_W     = H_W;              // (ceiling - floor) * 256, unsigned
  localparam int Q_W       = HEIGHT_W;         // quotient bits, one per divider stage
  localparam int DVD_W     = DEN_W + Q_W;      // num * 65535

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [7:0] ALPHA_MIN = 8'd8;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } cfg_reg_t;

  // How the final height is formed.
  typedef enum logic [1:0] {
    HC_ZERO = 2'd0,
    HC_SAT  = 2'd1,
    HC_DIV  = 2'd2
  } hcls_t;

  typedef struct packed {
    logic                     pos;       // ceiling above floor
    logic signed [H_W-1:0]    floor_q8;  // floor * 256
    logic [DEN_W-1:0]         den;       // (ceiling - floor) * 256
  } cfg_t;

  typedef struct packed {
    logic               elev;
    logic               we;
    logic [COLOR_W-1:0] color;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    hcls_t              cls;
    logic [DVD_W-1:0]   dividend;
  } div_in_t;

  typedef struct packed {
    logic                we;
    logic                is_height;
    logic [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]  color;
  } res_t;

  // Terrarium decode: R:G:B minus 2^23, as signed Q.8 metres.
  function automatic logic signed [H_W-1:0] terrarium_q8(input logic [TEXEL_W-1:0] t);
    terrarium_q8 = {~t[H_W-1], t[H_W-2:0]};
  endfunction

endpackage

FILE: hw/rtl/etr_cfg.sv
module etr_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [etr_pkg::CFG_W-1:0]    cfg_data,
  output etr_pkg::cfg_t                cfg
);

  logic signed [etr_pkg::CFG_W-1:0] floor_metres;
  logic signed [etr_pkg::CFG_W-1:0] ceiling_metres;
  logic signed [etr_pkg::CFG_W:0]   span;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_metres   <= '0;
      ceiling_metres <= 16'sd8192;
    end else if (cfg_valid) begin
      unique case (etr_pkg::cfg_reg_t'(cfg_index))
        etr_pkg::REG_FLOOR:   floor_metres   <= cfg_data;
        etr_pkg::REG_CEILING: ceiling_metres <= cfg_data;
        default: ;
      endcase
    end
  end

  assign span = {ceiling_metres[etr_pkg::CFG_W-1], ceiling_metres}
              - {floor_metres[etr_pkg::CFG_W-1], floor_metres};

  // Derived values are registered so that no subtract sits in the datapath.
  always_ff @(posedge clk) begin
    cfg.pos      <= span > 0;
    cfg.floor_q8 <= {floor_metres, 8'd0};
    cfg.den      <= {span[etr_pkg::CFG_W-1:0], 8'd0};
  end

endmodule

FILE: hw/rtl/etr_interp.sv
module etr_interp #(
  parameter int FRAC_BITS = etr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          elevation_mode,
  input  logic                          sparse_layer,
  input  logic [etr_pkg::TEXEL_W-1:0]   texel_top_left,
  input  logic [etr_pkg::TEXEL_W-1:0]   texel_top_right,
  input  logic [etr_pkg::TEXEL_W-1:0]   texel_bottom_left,
  input  logic [etr_pkg::TEXEL_W-1:0]   texel_bottom_right,
  input  logic [etr_pkg::FX_W-1:0]      frac_x,
  input  logic [etr_pkg::FX_W-1:0]      frac_y,
  input  etr_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output etr_pkg::div_in_t              out_data
);

  localparam int NSTAGE = 9;
  localparam logic [etr_pkg::FX_W-1:0] FMASK =
    (FRAC_BITS >= etr_pkg::FX_W) ? '1 : etr_pkg::FX_W'((32'd1 << FRAC_BITS) - 32'd1);
  localparam logic [31:0] HALF = 32'd1 << (FRAC_BITS - 1);

  logic [NSTAGE:1] v;

  // Stage registers.
  logic signed [etr_pkg::H_W-1:0]    h_tl, h_tr, h_bl, h_br;
  logic [etr_pkg::FX_W-1:0]          fx1, fy1, fx2, fy2, fy3, fy4, fy5;
  etr_pkg::meta_t                    meta1, meta2, meta3, meta4, meta5, meta6, meta7, meta8;
  logic signed [etr_pkg::H_W-1:0]    a_t2, a_b2, a_t3, a_b3;
  logic signed [etr_pkg::DIFF_W-1:0] d_t2, d_b2, d_v5;
  logic signed [etr_pkg::PROD_W-1:0] p_t3, p_b3, p_v6;
  logic signed [etr_pkg::H_W-1:0]    top4, bot4, top5, top6, m7;
  logic signed [etr_pkg::NUM_W-1:0]  num8;

  // Front-end combinational terms.
  logic [etr_pkg::FX_W-1:0]          fxm, fym;
  logic                              right, down, skip;
  logic [etr_pkg::TEXEL_W-1:0]       nearest;
  etr_pkg::meta_t                    meta_in;
  logic signed [etr_pkg::PROD_W-1:0] sh_t, sh_b, sh_v;
  logic [etr_pkg::H_W-1:0]           dv_m;
  logic                              num_pos, num_sat;
  etr_pkg::hcls_t                    cls_next;

  always_comb begin
    fxm     = frac_x & FMASK;
    fym     = frac_y & FMASK;
    right   = {16'd0, fxm} >= HALF;
    down    = {16'd0, fym} >= HALF;
    case ({down, right})
      2'b00:   nearest = texel_top_left;
      2'b01:   nearest = texel_top_right;
      2'b10:   nearest = texel_bottom_left;
      default: nearest = texel_bottom_right;
    endcase
    skip          = sparse_layer && (nearest[31:24] < etr_pkg::ALPHA_MIN);
    meta_in.elev  = elevation_mode;
    meta_in.we    = elevation_mode || !skip;
    meta_in.color = (elevation_mode || skip) ? '0 : nearest[etr_pkg::COLOR_W-1:0];
  end

  // Arithmetic right shift keeps the floor of the signed product.
  assign sh_t = p_t3 >>> FRAC_BITS;
  assign sh_b = p_b3 >>> FRAC_BITS;
  assign sh_v = p_v6 >>> FRAC_BITS;

  always_comb begin
    num_pos = num8 > 0;
    num_sat = num8 >= $signed({1'b0, cfg.den});
    if (!meta8.elev || !cfg.pos || !num_pos) begin
      cls_next = etr_pkg::HC_ZERO;
    end else if (num_sat) begin
      cls_next = etr_pkg::HC_SAT;
    end else begin
      cls_next = etr_pkg::HC_DIV;
    end
  end

  assign dv_m = num8[etr_pkg::H_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTAGE-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: decode heights and pick the nearest texel.
      h_tl  <= etr_pkg::terrarium_q8(texel_top_left);
      h_tr  <= etr_pkg::terrarium_q8(texel_top_right);
      h_bl  <= etr_pkg::terrarium_q8(texel_bottom_left);
      h_br  <= etr_pkg::terrarium_q8(texel_bottom_right);
      fx1   <= fxm;
      fy1   <= fym;
      meta1 <= meta_in;
      // Stage 2: horizontal differences.
      a_t2  <= h_tl;
      a_b2  <= h_bl;
      d_t2  <= etr_pkg::DIFF_W'(h_tr) - etr_pkg::DIFF_W'(h_tl);
      d_b2  <= etr_pkg::DIFF_W'(h_br) - etr_pkg::DIFF_W'(h_bl);
      fx2   <= fx1;
      fy2   <= fy1;
      meta2 <= meta1;
      // Stage 3: horizontal products.
      a_t3  <= a_t2;
      a_b3  <= a_b2;
      p_t3  <= d_t2 * $signed({1'b0, fx2});
      p_b3  <= d_b2 * $signed({1'b0, fx2});
      fy3   <= fy2;
      meta3 <= meta2;
      // Stage 4: top and bottom rows.
      top4  <= a_t3 + sh_t[etr_pkg::H_W-1:0];
      bot4  <= a_b3 + sh_b[etr_pkg::H_W-1:0];
      fy4   <= fy3;
      meta4 <= meta3;
      // Stage 5: vertical difference.
      top5  <= top4;
      d_v5  <= etr_pkg::DIFF_W'(bot4) - etr_pkg::DIFF_W'(top4);
      fy5   <= fy4;
      meta5 <= meta4;
      // Stage 6: vertical product.
      top6  <= top5;
      p_v6  <= d_v5 * $signed({1'b0, fy5});
      meta6 <= meta5;
      // Stage 7: interpolated height.
      m7    <= top6 + sh_v[etr_pkg::H_W-1:0];
      meta7 <= meta6;
      // Stage 8: offset from the floor.
      num8  <= etr_pkg::NUM_W'(m7) - etr_pkg::NUM_W'(cfg.floor_q8);
      meta8 <= meta7;
      // Stage 9: classify and form num * 65535 for the divider.
      out_data.meta     <= meta8;
      out_data.cls      <= cls_next;
      out_data.dividend <= {dv_m, 16'd0} - {16'd0, dv_m};
    end
  end

  assign out_valid = v[NSTAGE];

endmodule

FILE: hw/rtl/etr_div.sv
module etr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  etr_pkg::div_in_t              in_data,
  input  logic [etr_pkg::DEN_W-1:0]     den,
  output logic                          out_valid,
  output etr_pkg::res_t                 out_data
);

  localparam int NS = etr_pkg::Q_W;

  // One quotient bit per stage, restoring division.
  logic [NS-1:0]              v;
  logic [etr_pkg::DEN_W-1:0]  rem  [NS];
  logic [etr_pkg::Q_W-1:0]    lo   [NS];
  logic [etr_pkg::Q_W-1:0]    quo  [NS];
  etr_pkg::meta_t             meta [NS];
  etr_pkg::hcls_t             cls  [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [etr_pkg::DEN_W-1:0] rem_in;
    logic [etr_pkg::Q_W-1:0]   lo_in, quo_in;
    etr_pkg::meta_t            meta_in;
    etr_pkg::hcls_t            cls_in;
    logic [etr_pkg::DEN_W:0]   trial;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_in  = in_data.dividend[etr_pkg::DVD_W-1:etr_pkg::Q_W];
      assign lo_in   = in_data.dividend[etr_pkg::Q_W-1:0];
      assign quo_in  = '0;
      assign meta_in = in_data.meta;
      assign cls_in  = in_data.cls;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign lo_in   = lo[k-1];
      assign quo_in  = quo[k-1];
      assign meta_in = meta[k-1];
      assign cls_in  = cls[k-1];
    end

    assign trial = {rem_in, lo_in[etr_pkg::Q_W-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? etr_pkg::DEN_W'(trial - {1'b0, den}) : trial[etr_pkg::DEN_W-1:0];
        lo[k]   <= {lo_in[etr_pkg::Q_W-2:0], 1'b0};
        quo[k]  <= {quo_in[etr_pkg::Q_W-2:0], ge};
        meta[k] <= meta_in;
        cls[k]  <= cls_in;
      end
    end
  end

  always_comb begin
    out_data.we        = meta[NS-1].we;
    out_data.is_height = meta[NS-1].elev;
    out_data.color     = meta[NS-1].color;
    case (cls[NS-1])
      etr_pkg::HC_DIV: out_data.height = quo[NS-1];
      etr_pkg::HC_SAT: out_data.height = etr_pkg::HEIGHT_MAX;
      default:         out_data.height = '0;
    endcase
  end

  assign out_valid = v[NS-1];

`ifndef SYNTH
  // A division in progress always keeps its partial remainder below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] && cls[NS-1] == etr_pkg::HC_DIV |-> rem[NS-1] < den)
    else $error("divider remainder not below divisor");
`endif

endmodule

FILE: hw/rtl/etr_skid.sv
module etr_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  etr_pkg::res_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output etr_pkg::res_t     out_data
);

  logic          skid_valid;
  etr_pkg::res_t skid_data;
  logic          push, pop;

  // The pipeline runs while the spare slot is free, so ready upstream comes
  // from a register and never from out_ready.
  assign in_ready = !skid_valid;
  assign push     = in_valid && !skid_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= in_data;
      end
    end else if (push) begin
      skid_data <= in_data;
    end
  end

`ifndef SYNTH
  // The spare slot only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds data while output register is empty");

  // A stalled output with a filled spare slot keeps both slots full.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && out_valid)
    else $error("buffered transaction lost during stall");
`endif

endmodule

FILE: hw/rtl/elevation_texel_resampler_top.sv
// Elevation texel resampler: one destination pixel per transaction.
// Slave stream s_*: four BGRA texels around the sample point plus the
// bilinear weights in s_tdata, the tile kind in s_tuser. Master stream m_*:
// the write flag, height and color in m_tdata, the height flag in m_tuser.
// The cfg_* channel writes the floor (index 0) and ceiling (index 1) in
// whole metres; cfg_ready is always high. Write them only while the block
// holds no transaction, and allow two cycles before the next input.
// Throughput is one transaction per clock while s_tready is high, with no
// dependence between pixels. From input acceptance to m_tvalid a
// transaction passes nine interpolation stages (decode, difference,
// multiply, add in each axis, floor offset, classify), sixteen divider
// stages that each retire one quotient bit, and the output register.
// Synchronous reset empties the pipeline and sets floor 0 and ceiling 8192.
// When the receiver stalls, the output register plus one spare slot absorb
// the transaction in flight; s_tready then drops for the whole pipeline,
// which holds its contents until the spare slot drains. Nothing is lost or
// repeated, and s_tready never depends combinationally on m_tready.
module elevation_texel_resampler_top #(
  parameter int FRAC_BITS = etr_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input transactions.
  input  logic         s_tvalid,
  output logic         s_tready,
  // texel_top_left[31:0], texel_top_right[63:32], texel_bottom_left[95:64],
  // texel_bottom_right[127:96], frac_x[143:128], frac_y[159:144]
  input  logic [159:0] s_tdata,
  // elevation_mode[0], sparse_layer[1]
  input  logic [1:0]   s_tuser,
  // Result transactions.
  output logic         m_tvalid,
  input  logic         m_tready,
  // write_enable[0], height_value[16:1], color_rgb[40:17], zero fill[47:41]
  output logic [47:0]  m_tdata,
  // is_height[0]
  output logic [0:0]   m_tuser,
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  etr_pkg::cfg_t    cfg;
  logic             en;
  logic             ip_valid;
  etr_pkg::div_in_t ip_data;
  logic             dv_valid;
  etr_pkg::res_t    dv_data;
  etr_pkg::res_t    res;

  etr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The whole pipeline advances together; the skid buffer decides when.
  assign s_tready = en;

  etr_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk                (clk),
    .rst                (rst),
    .en                 (en),
    .in_valid           (s_tvalid),
    .elevation_mode     (s_tuser[0]),
    .sparse_layer       (s_tuser[1]),
    .texel_top_left     (s_tdata[31:0]),
    .texel_top_right    (s_tdata[63:32]),
    .texel_bottom_left  (s_tdata[95:64]),
    .texel_bottom_right (s_tdata[127:96]),
    .frac_x             (s_tdata[143:128]),
    .frac_y             (s_tdata[159:144]),
    .cfg                (cfg),
    .out_valid          (ip_valid),
    .out_data           (ip_data)
  );

  etr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ip_valid),
    .in_data   (ip_data),
    .den       (cfg.den),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  etr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (en),
    .in_data   (dv_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {7'd0, res.color, res.height, res.we};
  assign m_tuser = res.is_height;

`ifndef SYNTH
  // Height results are always written and carry no color.
  a_height_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[0] && m_tdata[40:17] == '0)
    else $error("height result with color or without write");

  // Color results carry no height.
  a_color_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[16:1] == '0)
    else $error("color result with nonzero height");
`endif

endmodule

FILE: tb/tb_elevation_texel_resampler_top.sv
module tb_elevation_texel_resampler_top;

  localparam int FRAC = etr_pkg::FRAC_BITS_DEF;
  // Weight at or above which the color path picks the right column or lower row.
  localparam logic [15:0] HALF_WEIGHT = 16'(1 << (FRAC - 1));
  // Receiver hold-off long enough to fill the pipeline and close s_tready.
  localparam int HOLD_CYCLES = 300;
  // Watchdog: cycles with no transaction on any channel before giving up.
  localparam int STALL_LIMIT = 3000;
  localparam int PIPE_CYCLES = 25;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 115;

  // Handy Terrarium texels, alpha opaque: 0 m, -32768 m, top of range, 8192 m.
  localparam logic [31:0] ZERO_M = 32'hFF80_0000;
  localparam logic [31:0] LOW_M  = 32'hFF00_0000;
  localparam logic [31:0] TOP_M  = 32'hFFFF_FFFF;
  localparam logic [31:0] M8192  = 32'hFFA0_0000;

  // Layout of s_tdata, lowest field last in the declaration.
  typedef struct packed {
    logic [15:0] fy;
    logic [15:0] fx;
    logic [31:0] br;
    logic [31:0] bl;
    logic [31:0] tr;
    logic [31:0] tl;
  } texel_quad_t;

  typedef struct packed {
    logic        sparse;
    logic        elev;
    texel_quad_t quad;
  } pixel_t;

  typedef enum {ROW_LIMITS, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    shortint       lim_floor;
    shortint       lim_ceil;
    pixel_t        px;
    logic          typed;
    etr_pkg::res_t want;
  } dir_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  // Sideband that travels with each offered transaction: when set, the row
  // carries its own expected result and the predictor is bypassed.
  logic          dir_typed = 1'b0;
  etr_pkg::res_t dir_want = '0;

  etr_pkg::res_t      expected_pixels[$];
  dir_row_t           dir_rows[$];
  logic signed [15:0] floor_live;
  logic signed [15:0] ceiling_live;
  int                 fault_count = 0;
  int                 shown = 0;

  logic     steady = 1'b0;
  int       burst_left = 0;
  int       hold_asks = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       beat = 0;
  int       quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  elevation_texel_resampler_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Terrarium decode: R:G:B read as Q.8 metres, offset by 32768 m.
  function automatic longint texel_q8(input logic [31:0] t);
    return longint'({40'b0, t[23:0]}) - 64'sd8388608;
  endfunction

  // One interpolation step; the arithmetic shift floors the product.
  function automatic longint blend(input longint a, input longint b, input logic [15:0] w);
    longint prod;
    prod = (b - a) * longint'({48'b0, w});
    return a + (prod >>> FRAC);
  endfunction

  // Expected destination pixel for one transaction under the given limits.
  function automatic etr_pkg::res_t resample_pixel(input pixel_t p,
                                                   input logic signed [15:0] lo_m,
                                                   input logic signed [15:0] hi_m);
    longint        upper;
    longint        lower;
    longint        mid;
    longint        num;
    longint        den;
    logic [31:0]   near;
    etr_pkg::res_t r;
    r = '0;
    if (p.elev) begin
      upper = blend(texel_q8(p.quad.tl), texel_q8(p.quad.tr), p.quad.fx);
      lower = blend(texel_q8(p.quad.bl), texel_q8(p.quad.br), p.quad.fx);
      mid = blend(upper, lower, p.quad.fy);
      r.we = 1'b1;
      r.is_height = 1'b1;
      // A ceiling at or below the floor leaves the height at zero.
      if (hi_m > lo_m) begin
        num = mid - longint'(lo_m) * 256;
        den = (longint'(hi_m) - longint'(lo_m)) * 256;
        if (num <= 0) begin
          r.height = '0;
        end else if (num >= den) begin
          r.height = etr_pkg::HEIGHT_MAX;
        end else begin
          r.height = 16'((num * 65535) / den);
        end
      end
    end else begin
      if (p.quad.fy >= HALF_WEIGHT) begin
        near = (p.quad.fx >= HALF_WEIGHT) ? p.quad.br : p.quad.bl;
      end else begin
        near = (p.quad.fx >= HALF_WEIGHT) ? p.quad.tr : p.quad.tl;
      end
      // Sparse layers skip nearly transparent texels entirely.
      if (!(p.sparse && near[31:24] < etr_pkg::ALPHA_MIN)) begin
        r.we = 1'b1;
        r.color = near[23:0];
      end
    end
    return r;
  endfunction

  task automatic report_fault(input string what, input etr_pkg::res_t want,
                              input etr_pkg::res_t got);
    fault_count++;
    if (shown < 10) begin
      shown++;
      $display("%s: expected we=%0b hgt=%0b height=%0d color=%06h",
               what, want.we, want.is_height, want.height, want.color);
      $display("  got we=%0b hgt=%0b height=%0d color=%06h",
               got.we, got.is_height, got.height, got.color);
    end
  endtask

  // The monitor follows all three channels at the clock edge. Configuration
  // transactions update the local copy of the limits, input transactions
  // queue their expected pixel, and output transactions are compared with
  // the oldest one queued.
  always @(posedge clk) begin : watch_pixels
    etr_pkg::res_t got;
    etr_pkg::res_t want;
    pixel_t        seen;
    if (rst) begin
      floor_live = 16'sd0;
      ceiling_live = 16'sd8192;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == etr_pkg::REG_FLOOR) begin
          floor_live = cfg_data;
        end else begin
          ceiling_live = cfg_data;
        end
      end
      if (m_tvalid && m_tready) begin
        got.we = m_tdata[0];
        got.height = m_tdata[16:1];
        got.color = m_tdata[40:17];
        got.is_height = m_tuser[0];
        if (expected_pixels.size() == 0) begin
          report_fault("result with nothing pending", '0, got);
        end else begin
          want = expected_pixels.pop_front();
          if (got.we !== want.we || got.is_height !== want.is_height ||
              got.height !== want.height || got.color !== want.color) begin
            report_fault("pixel mismatch", want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        seen.elev = s_tuser[0];
        seen.sparse = s_tuser[1];
        seen.quad = s_tdata;
        expected_pixels.push_back(dir_typed ? dir_want
                                            : resample_pixel(seen, floor_live, ceiling_live));
      end
    end
  end

  // The receiver switches among several stall patterns of random length,
  // one of which never stalls. A request from the stimulus process starts
  // a long hold-off that this process counts out on its own.
  always @(posedge clk) begin : receiver
    beat++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN: begin
          m_tready <= 1'b1;
        end
        RX_COIN: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        RX_PERIODIC: begin
          m_tready <= (beat % 4) != 0;
        end
        default: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Any channel moving counts as progress. A lost result shows up here too,
  // since the final drain would otherwise wait for it forever.
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_elevation_texel_resampler_top: errors");
      $finish;
    end
  end

  task automatic tab_limits(input shortint lo_m, input shortint hi_m);
    dir_row_t r;
    r.kind = ROW_LIMITS;
    r.lim_floor = lo_m;
    r.lim_ceil = hi_m;
    r.px = '0;
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic tab_pixel(input logic elev, input logic sparse,
                           input logic [31:0] tl, input logic [31:0] tr,
                           input logic [31:0] bl, input logic [31:0] br,
                           input logic [15:0] fx, input logic [15:0] fy,
                           input logic typed, input logic we,
                           input logic [15:0] height, input logic [23:0] color);
    dir_row_t r;
    r.kind = ROW_PIXEL;
    r.lim_floor = 0;
    r.lim_ceil = 0;
    r.px.elev = elev;
    r.px.sparse = sparse;
    r.px.quad = {fy, fx, br, bl, tr, tl};
    r.typed = typed;
    r.want.we = we;
    r.want.is_height = elev;
    r.want.height = height;
    r.want.color = color;
    dir_rows.push_back(r);
  endtask

  // Presents one transaction and returns at the edge that accepts it, with
  // s_tvalid still high so that a following transaction can go back to back.
  task automatic offer(input pixel_t p, input logic typed, input etr_pkg::res_t want);
    s_tvalid <= 1'b1;
    s_tdata <= p.quad;
    s_tuser <= {p.sparse, p.elev};
    dir_typed <= typed;
    dir_want <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every queued pixel has come back. Every
  // transaction yields a result, so the pipeline is empty at that point; a
  // few extra cycles are allowed anyway.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_pixels.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes floor then ceiling back to back, then leaves the gap that the
  // block asks for before the next input.
  task automatic program_limits(input shortint lo_m, input shortint hi_m);
    cfg_valid <= 1'b1;
    cfg_index <= etr_pkg::REG_FLOOR;
    cfg_data <= lo_m;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= etr_pkg::REG_CEILING;
    cfg_data <= hi_m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF + 16'($urandom_range(0, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  // A texel whose height lies within spread metres of base, random alpha.
  function automatic logic [31:0] height_texel(input int base, input int spread);
    int          metres;
    int          code;
    logic [31:0] noise;
    noise = $urandom;
    metres = base + int'($urandom_range(0, 2 * spread)) - spread;
    code = (metres + 32768) * 256 + int'($urandom_range(0, 255));
    if (code < 0) code = 0;
    if (code > 24'hFFFFFF) code = 24'hFFFFFF;
    return {noise[31:24], code[23:0]};
  endfunction

  // Random pixel. Most elevation pixels sit around the current limits so
  // that the division path gets exercised rather than the saturated ends;
  // color pixels often carry low alpha to hit the sparse threshold.
  function automatic pixel_t make_pixel(input int lo, input int hi);
    pixel_t p;
    int     a;
    int     b;
    int     base;
    int     spread;
    p.elev = ($urandom_range(0, 99) < 55);
    p.sparse = 1'($urandom_range(0, 1));
    p.quad.fx = pick_frac();
    p.quad.fy = pick_frac();
    if (p.elev && $urandom_range(0, 3) != 0) begin
      a = ((lo < hi) ? lo : hi) - 100;
      b = ((lo < hi) ? hi : lo) + 100;
      if (a < -32768) a = -32768;
      if (b > 32767) b = 32767;
      base = a + int'($urandom_range(0, b - a));
      spread = ($urandom_range(0, 1) != 0) ? 4 : 400;
      p.quad.tl = height_texel(base, spread);
      p.quad.tr = height_texel(base, spread);
      p.quad.bl = height_texel(base, spread);
      p.quad.br = height_texel(base, spread);
    end else begin
      p.quad.tl = $urandom;
      p.quad.tr = $urandom;
      p.quad.bl = $urandom;
      p.quad.br = $urandom;
      if (!p.elev && $urandom_range(0, 1) != 0) begin
        p.quad.tl[31:24] = 8'($urandom_range(0, 15));
        p.quad.tr[31:24] = 8'($urandom_range(0, 15));
        p.quad.bl[31:24] = 8'($urandom_range(0, 15));
        p.quad.br[31:24] = 8'($urandom_range(0, 15));
      end
    end
    return p;
  endfunction

  initial begin : stimulus
    int lo;
    int hi;

    // Directed table, run first at the reset limits (floor 0, ceiling 8192).
    // Flat tiles at the range ends saturate or zero and are typed in.
    tab_pixel(1, 0, ZERO_M, ZERO_M, ZERO_M, ZERO_M, 16'h0000, 16'h0000, 1, 1, 16'd0, 24'h0);
    tab_pixel(1, 0, TOP_M, TOP_M, TOP_M, TOP_M, 16'hFFFF, 16'hFFFF, 1, 1,
              etr_pkg::HEIGHT_MAX, 24'h0);
    tab_pixel(1, 0, LOW_M, LOW_M, LOW_M, LOW_M, 16'h8000, 16'h8000, 1, 1, 16'd0, 24'h0);
    tab_pixel(1, 0, M8192, M8192, M8192, M8192, 16'h1234, 16'hFEDC, 1, 1,
              etr_pkg::HEIGHT_MAX, 24'h0);
    // Real interpolation, left to the predictor.
    tab_pixel(1, 0, ZERO_M, M8192, ZERO_M, M8192, 16'h8000, 16'h0000, 0, 0, 16'd0, 24'h0);
    tab_pixel(1, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000,
              16'hFFFF, 16'hFFFF, 0, 0, 16'd0, 24'h0);
    // The sparse flag and a zero alpha do nothing to an elevation tile.
    tab_pixel(1, 1, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000,
              16'h1234, 16'h4321, 1, 1, 16'd0, 24'h0);
    // Color passthrough picks each of the four corners.
    tab_pixel(0, 0, 32'hFF12_3456, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
              16'h0000, 16'h0000, 1, 1, 16'd0, 24'h123456);
    tab_pixel(0, 0, 32'h0000_0001, 32'h80AB_CDEF, 32'h0000_0002, 32'h0000_0003,
              16'h8000, 16'h0000, 1, 1, 16'd0, 24'hABCDEF);
    tab_pixel(0, 0, 32'h0000_0001, 32'h0000_0002, 32'h7F65_4321, 32'h0000_0003,
              16'h7FFF, 16'h8000, 1, 1, 16'd0, 24'h654321);
    tab_pixel(0, 0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'hFFFF_FFFF,
              16'hFFFF, 16'hFFFF, 1, 1, 16'd0, 24'hFFFFFF);
    // Sparse threshold: alpha 7 suppresses the write, alpha 8 passes.
    tab_pixel(0, 1, 32'h07AB_CDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'h0000, 16'h0000, 1, 0, 16'd0, 24'h0);
    tab_pixel(0, 1, 32'h08AB_CDEF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              16'h0000, 16'h0000, 1, 1, 16'd0, 24'hABCDEF);
    tab_pixel(0, 0, 32'h0011_2233, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'h0000, 16'h0000, 1, 1, 16'd0, 24'h112233);
    tab_pixel(0, 1, 32'hFF00_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              16'h7FFF, 16'h7FFF, 1, 1, 16'd0, 24'h0);
    tab_pixel(0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF,
              16'hFFFF, 16'hFFFF, 1, 0, 16'd0, 24'h0);
    // Widest possible limits.
    tab_limits(-32768, 32767);
    tab_pixel(1, 0, LOW_M, LOW_M, LOW_M, LOW_M, 16'h0000, 16'h0000, 1, 1, 16'd0, 24'h0);
    tab_pixel(1, 0, TOP_M, TOP_M, TOP_M, TOP_M, 16'h0000, 16'h0000, 1, 1,
              etr_pkg::HEIGHT_MAX, 24'h0);
    tab_pixel(1, 0, 32'h5A12_3456, 32'hA5FE_DCBA, 32'h0F00_FF00, 32'hF0FF_00FF,
              16'h5555, 16'hAAAA, 0, 0, 16'd0, 24'h0);
    // Ceiling equal to and then below the floor: height zero, write kept.
    tab_limits(100, 100);
    tab_pixel(1, 0, TOP_M, TOP_M, TOP_M, TOP_M, 16'h0000, 16'h0000, 1, 1, 16'd0, 24'h0);
    tab_limits(32767, -32768);
    tab_pixel(1, 0, ZERO_M, ZERO_M, ZERO_M, ZERO_M, 16'h0001, 16'h0001, 1, 1, 16'd0, 24'h0);
    tab_pixel(0, 0, 32'hFFFE_DCBA, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              16'h0000, 16'h0000, 1, 1, 16'd0, 24'hFEDCBA);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_LIMITS) begin
        drain();
        program_limits(dir_rows[i].lim_floor, dir_rows[i].lim_ceil);
      end else begin
        offer(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
        pace();
      end
    end

    // Random phases, each under its own limits. Phase four asks the receiver
    // for a long hold-off while the sender streams without gaps, so the
    // pipeline fills and s_tready drops; phase five also streams steadily.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          lo = 0;
          hi = 8192;
        end
        1: begin
          lo = -32768;
          hi = 32767;
        end
        2: begin
          lo = int'($urandom_range(0, 65535)) - 32768;
          hi = lo;
        end
        3: begin
          lo = int'($urandom_range(0, 32767)) - 16384;
          hi = lo - int'($urandom_range(1, 16383));
        end
        default: begin
          lo = int'($urandom_range(0, 65534)) - 32768;
          hi = lo + int'($urandom_range(1, (ph % 3 == 0) ? 65535 : 4000));
          if (hi > 32767) hi = 32767;
        end
      endcase
      drain();
      program_limits(shortint'(lo), shortint'(hi));
      steady = (ph == 4 || ph == 5);
      if (ph == 4) hold_asks++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        offer(make_pixel(lo, hi), 1'b0, '0);
        pace();
      end
    end

    // Wait for the last results, then a little longer to catch any extra.
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_pixels.size() != 0);
    repeat (PIPE_CYCLES + 10) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_elevation_texel_resampler_top: clean");
    end else begin
      $display("tb_elevation_texel_resampler_top: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/etr_pkg.sv
hw/rtl/etr_cfg.sv
hw/rtl/etr_interp.sv
hw/rtl/etr_div.sv
hw/rtl/etr_skid.sv
hw/rtl/elevation_texel_resampler_top.sv
tb/tb_elevation_texel_resampler_top.sv
